// ===== src/ctc_pkg.sv =====
// shared types, codes and helpers for the contextual token classifier
package ctc_pkg;

	localparam int GroupDepthDefault = 32;

	// raw token kinds
	localparam logic [3:0] RK_WORD = 4'd0;
	localparam logic [3:0] RK_NUMBER = 4'd1;
	localparam logic [3:0] RK_STRING = 4'd2;
	localparam logic [3:0] RK_SEMI = 4'd3;
	localparam logic [3:0] RK_COLON = 4'd4;
	localparam logic [3:0] RK_EQUAL = 4'd5;
	localparam logic [3:0] RK_COMMA = 4'd6;
	localparam logic [3:0] RK_LPAREN = 4'd7;
	localparam logic [3:0] RK_RPAREN = 4'd8;
	localparam logic [3:0] RK_PLUS = 4'd9;
	localparam logic [3:0] RK_MINUS = 4'd10;
	localparam logic [3:0] RK_BSLASH = 4'd11;
	localparam logic [3:0] RK_DOT = 4'd12;
	localparam logic [3:0] RK_EOL = 4'd13;
	localparam logic [3:0] RK_EOS = 4'd14;
	localparam logic [3:0] RK_UNKNOWN = 4'd15;

	// token classes
	localparam logic [4:0] C_LABEL = 5'd0;
	localparam logic [4:0] C_COLON = 5'd1;
	localparam logic [4:0] C_EOC = 5'd2;
	localparam logic [4:0] C_VAR = 5'd3;
	localparam logic [4:0] C_THEN = 5'd4;
	localparam logic [4:0] C_ELSE = 5'd5;
	localparam logic [4:0] C_WITH = 5'd6;
	localparam logic [4:0] C_KEYWORD = 5'd7;
	localparam logic [4:0] C_WHEN = 5'd8;
	localparam logic [4:0] C_OTHERWISE = 5'd9;
	localparam logic [4:0] C_END = 5'd10;
	localparam logic [4:0] C_NUMBER = 5'd11;
	localparam logic [4:0] C_STRING = 5'd12;
	localparam logic [4:0] C_DOT = 5'd13;
	localparam logic [4:0] C_EQUAL = 5'd14;
	localparam logic [4:0] C_PLUS = 5'd15;
	localparam logic [4:0] C_MINUS = 5'd16;
	localparam logic [4:0] C_NOT = 5'd17;
	localparam logic [4:0] C_OPEN = 5'd18;
	localparam logic [4:0] C_CLOSE = 5'd19;
	localparam logic [4:0] C_COMMA = 5'd20;
	localparam logic [4:0] C_EOS = 5'd21;
	localparam logic [4:0] C_CONCAT = 5'd22;
	localparam logic [4:0] C_BLANK_CONCAT = 5'd23;

	// token roles
	localparam logic [3:0] R_LABEL = 4'd0;
	localparam logic [3:0] R_PUNCT = 4'd1;
	localparam logic [3:0] R_SYN_EOC = 4'd2;
	localparam logic [3:0] R_IDENT = 4'd3;
	localparam logic [3:0] R_KEYWORD = 4'd4;
	localparam logic [3:0] R_END_NAME = 4'd5;
	localparam logic [3:0] R_PARSE_TARGET = 4'd6;
	localparam logic [3:0] R_LITERAL = 4'd7;
	localparam logic [3:0] R_PARSE_DROP = 4'd8;
	localparam logic [3:0] R_OPERATOR = 4'd9;
	localparam logic [3:0] R_EOC = 4'd10;
	localparam logic [3:0] R_EOS = 4'd11;
	localparam logic [3:0] R_CONCAT = 4'd12;

	// keyword codes
	localparam logic [5:0] K_NONE = 6'd0;
	localparam logic [5:0] K_ADDRESS = 6'd1;
	localparam logic [5:0] K_ARG = 6'd2;
	localparam logic [5:0] K_DO = 6'd4;
	localparam logic [5:0] K_IF = 6'd7;
	localparam logic [5:0] K_PARSE = 6'd14;
	localparam logic [5:0] K_PULL = 6'd16;
	localparam logic [5:0] K_SELECT = 6'd21;
	localparam logic [5:0] K_TRACE = 6'd23;
	localparam logic [5:0] K_TO = 6'd24;
	localparam logic [5:0] K_FOREVER = 6'd29;
	localparam logic [5:0] K_UPPER = 6'd30;
	localparam logic [5:0] K_VALUE = 6'd34;
	localparam logic [5:0] K_WITH = 6'd36;
	localparam logic [5:0] K_INPUT = 6'd37;
	localparam logic [5:0] K_REPLACE = 6'd44;
	localparam logic [5:0] K_THEN = 6'd45;
	localparam logic [5:0] K_ELSE = 6'd46;
	localparam logic [5:0] K_WHEN = 6'd47;
	localparam logic [5:0] K_OTHERWISE = 6'd48;
	localparam logic [5:0] K_END = 6'd49;

	// parse sub-modes
	localparam logic [1:0] PS_NONE = 2'd0;
	localparam logic [1:0] PS_HEADER = 2'd1;
	localparam logic [1:0] PS_VALUE = 2'd2;
	localparam logic [1:0] PS_TEMPLATE = 2'd3;

	// one classified token
	typedef struct packed {
		logic [4:0] token_class;
		logic [5:0] keyword_echo;
		logic [3:0] token_role;
		logic is_synthetic;
	} tok_t;

	// everything one input item produces: up to three tokens
	typedef struct packed {
		logic [1:0] count;
		tok_t [2:0] toks;
	} bundle_t;

	function automatic tok_t mk_tok(logic [4:0] c, logic [5:0] e, logic [3:0] r, logic s);
		tok_t t;
		t.token_class = c;
		t.keyword_echo = e;
		t.token_role = r;
		t.is_synthetic = s;
		return t;
	endfunction

	// keyword token, named after the word itself for THEN, ELSE, WITH, WHEN, OTHERWISE and END
	function automatic tok_t named_tok(logic [5:0] k);
		tok_t t;
		case (k)
			K_THEN: t = mk_tok(C_THEN, K_NONE, R_KEYWORD, 1'b0);
			K_ELSE: t = mk_tok(C_ELSE, K_NONE, R_KEYWORD, 1'b0);
			K_WITH: t = mk_tok(C_WITH, K_NONE, R_KEYWORD, 1'b0);
			K_WHEN: t = mk_tok(C_WHEN, K_NONE, R_KEYWORD, 1'b0);
			K_OTHERWISE: t = mk_tok(C_OTHERWISE, K_NONE, R_KEYWORD, 1'b0);
			K_END: t = mk_tok(C_END, K_NONE, R_KEYWORD, 1'b0);
			default: t = mk_tok(C_KEYWORD, k, R_KEYWORD, 1'b0);
		endcase
		return t;
	endfunction

endpackage

// ===== src/ctc_front.sv =====
// front end: keeps clause context, maps raw tokens to bundles or drops them
module ctc_front import ctc_pkg::*; #(
	parameter int GROUP_DEPTH = GroupDepthDefault
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [3:0] raw_kind,
	input logic [5:0] keyword_code,
	input logic space_before,
	input logic next_is_colon,
	input logic next_is_equal,
	output logic bq_valid,
	input logic bq_full,
	output bundle_t bq_data
);

	localparam int DW = $clog2(GROUP_DEPTH + 1);
	localparam int AW = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;

	logic at_clause_start_q, in_if_q, in_when_q, in_do_spec_q, operand_pending_q;
	logic after_end_q, address_tail_q, absorb_colon_q;
	logic [7:0] else_cnt_q;
	logic [1:0] parse_state_q;
	logic [DW-1:0] depth_q;
	logic group_kinds_q [GROUP_DEPTH];
	logic top_kind_q;

	logic acc;
	assign in_stall = bq_full;
	assign acc = in_valid && !bq_full;

	// next-state values
	logic n_acs, n_if, n_when, n_dos, n_op, n_aew, n_at, n_abs;
	logic [7:0] n_else;
	logic [1:0] n_ps;
	logic [DW-1:0] n_depth;
	logic push_en, push_kind;
	bundle_t b;

	logic [5:0] k;
	logic sel_open, concat_due, w_done;
	tok_t concat_tok, eoc_tok;

	assign k = (keyword_code > K_END) ? K_NONE : keyword_code;
	assign sel_open = (depth_q != '0) && top_kind_q;
	assign concat_tok = mk_tok(space_before ? C_BLANK_CONCAT : C_CONCAT, K_NONE, R_CONCAT, 1'b1);
	assign eoc_tok = mk_tok(C_EOC, K_NONE, R_SYN_EOC, 1'b1);

	// classification of the current raw token against the context
	always_comb begin
		n_acs = at_clause_start_q; n_if = in_if_q; n_when = in_when_q;
		n_dos = in_do_spec_q; n_op = operand_pending_q; n_aew = after_end_q;
		n_at = address_tail_q; n_abs = 1'b0; n_else = else_cnt_q;
		n_ps = parse_state_q; n_depth = depth_q; push_en = 1'b0; push_kind = 1'b0;
		b = '0;
		concat_due = operand_pending_q && !at_clause_start_q && raw_kind != RK_EOS
			&& raw_kind != RK_SEMI && raw_kind != RK_EOL && raw_kind != RK_RPAREN
			&& raw_kind != RK_COMMA;
		w_done = 1'b0;
		if (raw_kind == RK_UNKNOWN || (absorb_colon_q && raw_kind == RK_COLON)) begin
			n_abs = 1'b0;
		end else begin
			case (raw_kind)
				RK_WORD: begin
					if (at_clause_start_q && next_is_colon) begin
						b.count = 2'd3;
						b.toks[0] = mk_tok(C_LABEL, K_NONE, R_LABEL, 1'b0);
						b.toks[1] = mk_tok(C_COLON, K_NONE, R_PUNCT, 1'b0);
						b.toks[2] = eoc_tok;
						n_abs = 1'b1; n_acs = 1'b1; n_dos = 1'b0; n_ps = PS_NONE;
						n_at = 1'b0; n_op = 1'b0; n_aew = 1'b0;
					end else if ((at_clause_start_q || in_do_spec_q) && next_is_equal) begin
						if (concat_due) begin
							b.count = 2'd2; b.toks[0] = concat_tok;
							b.toks[1] = mk_tok(C_VAR, K_NONE, R_IDENT, 1'b0);
						end else begin
							b.count = 2'd1; b.toks[0] = mk_tok(C_VAR, K_NONE, R_IDENT, 1'b0);
						end
						n_acs = 1'b0; n_op = 1'b0;
					end else if ((in_if_q || in_when_q) && k == K_THEN) begin
						b.count = 2'd3; b.toks[0] = eoc_tok;
						b.toks[1] = mk_tok(C_THEN, K_NONE, R_KEYWORD, 1'b0);
						b.toks[2] = eoc_tok;
						if (in_if_q && else_cnt_q != 8'd255) n_else = else_cnt_q + 8'd1;
						n_if = 1'b0; n_when = 1'b0; n_acs = 1'b1; n_op = 1'b0;
					end else if (k == K_ELSE && else_cnt_q != 8'd0) begin
						b.count = 2'd2;
						b.toks[0] = mk_tok(C_ELSE, K_NONE, R_KEYWORD, 1'b0);
						b.toks[1] = eoc_tok;
						n_else = else_cnt_q - 8'd1; n_acs = 1'b1; n_op = 1'b0;
					end else if (after_end_q) begin
						b.count = 2'd1; b.toks[0] = mk_tok(C_VAR, K_NONE, R_END_NAME, 1'b0);
						n_aew = 1'b0; w_done = 1'b1;
					end else if (parse_state_q == PS_TEMPLATE) begin
						b.count = 2'd1;
						b.toks[0] = mk_tok(C_VAR, K_NONE, R_PARSE_TARGET, 1'b0);
						w_done = 1'b1;
					end else if (parse_state_q == PS_VALUE && k == K_WITH) begin
						b.count = 2'd1; b.toks[0] = mk_tok(C_WITH, K_NONE, R_KEYWORD, 1'b0);
						n_ps = PS_TEMPLATE; w_done = 1'b1;
					end else if (parse_state_q == PS_HEADER && (k == K_ARG || k == K_PULL
							|| (k >= K_UPPER && k <= K_WITH))) begin
						b.count = 2'd1; b.toks[0] = named_tok(k);
						n_ps = (k == K_VALUE) ? PS_VALUE : PS_TEMPLATE; w_done = 1'b1;
					end else if (address_tail_q && (k == K_VALUE || k == K_WITH
							|| (k >= K_INPUT && k <= K_REPLACE))) begin
						b.count = 2'd1; b.toks[0] = named_tok(k); w_done = 1'b1;
					end else if (in_do_spec_q && k >= K_TO && k <= K_FOREVER) begin
						b.count = 2'd1; b.toks[0] = named_tok(k); w_done = 1'b1;
					end else if (at_clause_start_q && sel_open && k == K_WHEN) begin
						b.count = 2'd1; b.toks[0] = mk_tok(C_WHEN, K_NONE, R_KEYWORD, 1'b0);
						n_when = 1'b1; w_done = 1'b1;
					end else if (at_clause_start_q && sel_open && k == K_OTHERWISE) begin
						b.count = 2'd2;
						b.toks[0] = mk_tok(C_OTHERWISE, K_NONE, R_KEYWORD, 1'b0);
						b.toks[1] = eoc_tok; n_op = 1'b0;
					end else if (at_clause_start_q && k >= K_THEN && k <= K_OTHERWISE) begin
						b.toks[0] = named_tok(k);
						b.toks[1] = eoc_tok;
						b.count = (k == K_WHEN) ? 2'd1 : 2'd2;
						n_op = 1'b0;
					end else if (at_clause_start_q && k == K_END) begin
						b.count = 2'd1; b.toks[0] = mk_tok(C_END, K_NONE, R_KEYWORD, 1'b0);
						if (depth_q != '0) n_depth = depth_q - DW'(1);
						n_aew = 1'b1; w_done = 1'b1;
					end else if (at_clause_start_q && k >= K_ADDRESS && k <= K_TRACE) begin
						b.count = 2'd1; b.toks[0] = mk_tok(C_KEYWORD, k, R_KEYWORD, 1'b0);
						if (k == K_IF) n_if = 1'b1;
						if (k == K_DO) begin
							n_dos = 1'b1; push_en = 1'b1; push_kind = 1'b0;
						end
						if (k == K_SELECT) begin
							push_en = 1'b1; push_kind = 1'b1;
						end
						if (k == K_PARSE) n_ps = PS_HEADER;
						if (k == K_ADDRESS) n_at = 1'b1;
						w_done = 1'b1;
					end else begin
						if (concat_due) begin
							b.count = 2'd2; b.toks[0] = concat_tok;
							b.toks[1] = mk_tok(C_VAR, K_NONE, R_IDENT, 1'b0);
						end else begin
							b.count = 2'd1; b.toks[0] = mk_tok(C_VAR, K_NONE, R_IDENT, 1'b0);
						end
						n_acs = 1'b0; n_op = 1'b1;
					end
					if (w_done) begin
						n_acs = 1'b0; n_op = 1'b0;
					end
				end
				RK_NUMBER, RK_STRING: begin
					if (concat_due) begin
						b.count = 2'd2; b.toks[0] = concat_tok;
						b.toks[1] = mk_tok((raw_kind == RK_NUMBER) ? C_NUMBER : C_STRING,
							K_NONE, R_LITERAL, 1'b0);
					end else begin
						b.count = 2'd1;
						b.toks[0] = mk_tok((raw_kind == RK_NUMBER) ? C_NUMBER : C_STRING,
							K_NONE, R_LITERAL, 1'b0);
					end
					n_acs = 1'b0; n_op = 1'b1;
				end
				RK_LPAREN: begin
					if (concat_due) begin
						b.count = 2'd2; b.toks[0] = concat_tok;
						b.toks[1] = mk_tok(C_OPEN, K_NONE, R_PUNCT, 1'b0);
					end else begin
						b.count = 2'd1; b.toks[0] = mk_tok(C_OPEN, K_NONE, R_PUNCT, 1'b0);
					end
					n_acs = 1'b0; n_op = 1'b0;
				end
				RK_RPAREN: begin
					b.count = 2'd1; b.toks[0] = mk_tok(C_CLOSE, K_NONE, R_PUNCT, 1'b0);
					n_acs = 1'b0; n_op = 1'b1;
				end
				RK_SEMI, RK_EOL: begin
					b.count = 2'd1; b.toks[0] = mk_tok(C_EOC, K_NONE, R_EOC, 1'b0);
					n_acs = 1'b1; n_dos = 1'b0; n_ps = PS_NONE; n_at = 1'b0;
					n_op = 1'b0; n_aew = 1'b0;
				end
				RK_EOS: begin
					b.count = 2'd1; b.toks[0] = mk_tok(C_EOS, K_NONE, R_EOS, 1'b0);
					n_acs = 1'b1; n_if = 1'b0; n_when = 1'b0; n_dos = 1'b0; n_op = 1'b0;
					n_aew = 1'b0; n_else = '0; n_ps = PS_NONE; n_at = 1'b0; n_depth = '0;
				end
				default: begin
					// dot and single operators and punctuation
					b.count = 2'd1;
					case (raw_kind)
						RK_DOT: b.toks[0] = mk_tok(C_DOT, K_NONE,
							(parse_state_q == PS_TEMPLATE) ? R_PARSE_DROP : R_PUNCT, 1'b0);
						RK_EQUAL: b.toks[0] = mk_tok(C_EQUAL, K_NONE, R_OPERATOR, 1'b0);
						RK_PLUS: b.toks[0] = mk_tok(C_PLUS, K_NONE, R_OPERATOR, 1'b0);
						RK_MINUS: b.toks[0] = mk_tok(C_MINUS, K_NONE, R_OPERATOR, 1'b0);
						RK_BSLASH: b.toks[0] = mk_tok(C_NOT, K_NONE, R_OPERATOR, 1'b0);
						RK_COMMA: b.toks[0] = mk_tok(C_COMMA, K_NONE, R_PUNCT, 1'b0);
						default: b.toks[0] = mk_tok(C_COLON, K_NONE, R_PUNCT, 1'b0);
					endcase
					n_acs = 1'b0; n_op = 1'b0;
				end
			endcase
		end
		if (push_en && depth_q < DW'(GROUP_DEPTH)) n_depth = depth_q + DW'(1);
		else if (push_en) push_en = 1'b0;
	end

	// context registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_clause_start_q <= 1'b1; in_if_q <= 1'b0; in_when_q <= 1'b0;
			in_do_spec_q <= 1'b0; operand_pending_q <= 1'b0; after_end_q <= 1'b0;
			address_tail_q <= 1'b0; absorb_colon_q <= 1'b0; else_cnt_q <= '0;
			parse_state_q <= PS_NONE; depth_q <= '0; top_kind_q <= 1'b0;
		end else if (acc && raw_kind != RK_UNKNOWN) begin
			at_clause_start_q <= n_acs; in_if_q <= n_if; in_when_q <= n_when;
			in_do_spec_q <= n_dos; operand_pending_q <= n_op; after_end_q <= n_aew;
			address_tail_q <= n_at; absorb_colon_q <= n_abs; else_cnt_q <= n_else;
			parse_state_q <= n_ps; depth_q <= n_depth;
			// kind of the group now on top
			if (push_en) top_kind_q <= push_kind;
			else if (n_depth != '0 && n_depth != depth_q)
				top_kind_q <= group_kinds_q[AW'(n_depth - DW'(1))];
		end
	end

	// group kind stack
	always_ff @(posedge clk) begin
		if (acc && push_en) group_kinds_q[AW'(depth_q)] <= push_kind;
	end

	assign bq_valid = acc && b.count != 2'd0;
	assign bq_data = b;

endmodule

// ===== src/ctc_queue.sv =====
// short bundle queue between the front end and the token emitter
module ctc_queue import ctc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic full,
	input bundle_t wr_data,
	output logic rd_valid,
	input logic rd_take,
	output bundle_t rd_data
);

	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	bundle_t mem_q [4];

	assign full = cnt_q[2];
	assign rd_valid = cnt_q != 3'd0;
	assign rd_data = mem_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr_valid) wp_q <= wp_q + 2'd1;
			if (rd_take) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, wr_valid} - {2'd0, rd_take};
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (wr_valid) mem_q[wp_q] <= wr_data;
	end

endmodule

// ===== src/ctc_back.sv =====
// back end: plays each bundle out as single token transfers
module ctc_back import ctc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic bq_valid,
	output logic bq_take,
	input bundle_t bq_data,
	output logic out_valid,
	input logic out_stall,
	output logic [4:0] token_class,
	output logic [5:0] keyword_echo,
	output logic [3:0] token_role,
	output logic is_synthetic,
	output logic last_of_run
);

	logic [1:0] idx_q;
	logic fire, last;
	tok_t t;

	assign t = bq_data.toks[idx_q];
	assign last = (idx_q + 2'd1) == bq_data.count;
	assign out_valid = bq_valid;
	assign fire = bq_valid && !out_stall;
	assign bq_take = fire && last;
	assign token_class = t.token_class;
	assign keyword_echo = t.keyword_echo;
	assign token_role = t.token_role;
	assign is_synthetic = t.is_synthetic;
	assign last_of_run = last;

	// position within the bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) idx_q <= '0;
		else if (fire) idx_q <= last ? 2'd0 : idx_q + 2'd1;
	end

endmodule

// ===== src/contextual_token_classifier_top.sv =====
// top level of the contextual token classifier
// One raw token is taken per cycle while the internal four-entry queue has room; it produces
// up to three classified tokens, delivered one per cycle while the receiver does not stall,
// so throughput is set by the output side. Context is updated in the cycle the token is
// taken, so the next token can follow at once.
module contextual_token_classifier_top import ctc_pkg::*; #(
	parameter int GROUP_DEPTH = GroupDepthDefault
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [3:0] raw_kind,
	input logic [5:0] keyword_code,
	input logic space_before,
	input logic next_is_colon,
	input logic next_is_equal,
	output logic out_valid,
	input logic out_stall,
	output logic [4:0] token_class,
	output logic [5:0] keyword_echo,
	output logic [3:0] token_role,
	output logic is_synthetic,
	output logic last_of_run
);

	logic f_valid, q_full, q_valid, q_take;
	bundle_t f_data, q_data;

	// classifier front end
	ctc_front #(.GROUP_DEPTH(GROUP_DEPTH)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .raw_kind, .keyword_code, .space_before,
		.next_is_colon, .next_is_equal,
		.bq_valid(f_valid), .bq_full(q_full), .bq_data(f_data)
	);

	// decoupling queue
	ctc_queue u_queue (
		.clk, .arst_n, .wr_valid(f_valid), .full(q_full), .wr_data(f_data),
		.rd_valid(q_valid), .rd_take(q_take), .rd_data(q_data)
	);

	// token emitter
	ctc_back u_back (
		.clk, .arst_n, .bq_valid(q_valid), .bq_take(q_take), .bq_data(q_data),
		.out_valid, .out_stall, .token_class, .keyword_echo, .token_role,
		.is_synthetic, .last_of_run
	);

endmodule

// ===== test/ctc_checker.sv =====
// channel monitor, context predictor and token comparator for the classifier testbench
module ctc_checker import ctc_pkg::*; #(
	parameter int GROUP_DEPTH = GroupDepthDefault
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic [3:0] raw_kind,
	input logic [5:0] keyword_code,
	input logic space_before,
	input logic next_is_colon,
	input logic next_is_equal,
	input logic out_valid,
	input logic out_stall,
	input logic [4:0] token_class,
	input logic [5:0] keyword_echo,
	input logic [3:0] token_role,
	input logic is_synthetic,
	input logic last_of_run,
	output int failures,
	output int pending_count
);

	typedef struct packed {
		tok_t tok;
		logic last;
	} run_tok_t;

	run_tok_t pending_tokens[$];

	// predicted clause context
	logic at_start, if_cond, when_cond, do_spec, operand_open, end_name_due;
	logic [7:0] else_count;
	logic [1:0] parse_phase;
	logic addr_tail, colon_swallow;
	logic group_is_select [GROUP_DEPTH];
	int unsigned open_groups;

	// tokens produced by the transfer being predicted
	tok_t step_toks [3];
	int step_n;

	function automatic void clear_context();
		at_start = 1'b1;
		if_cond = 1'b0;
		when_cond = 1'b0;
		do_spec = 1'b0;
		operand_open = 1'b0;
		end_name_due = 1'b0;
		else_count = 8'd0;
		parse_phase = PS_NONE;
		addr_tail = 1'b0;
		open_groups = 0;
		colon_swallow = 1'b0;
	endfunction

	function automatic void emit(logic [4:0] c, logic [5:0] e, logic [3:0] r, logic s);
		if (step_n < 3) begin
			step_toks[step_n] = mk_tok(c, e, r, s);
			step_n++;
		end
	endfunction

	function automatic void emit_named(logic [5:0] k);
		case (k)
			K_THEN: emit(C_THEN, K_NONE, R_KEYWORD, 1'b0);
			K_ELSE: emit(C_ELSE, K_NONE, R_KEYWORD, 1'b0);
			K_WITH: emit(C_WITH, K_NONE, R_KEYWORD, 1'b0);
			K_WHEN: emit(C_WHEN, K_NONE, R_KEYWORD, 1'b0);
			K_OTHERWISE: emit(C_OTHERWISE, K_NONE, R_KEYWORD, 1'b0);
			K_END: emit(C_END, K_NONE, R_KEYWORD, 1'b0);
			default: emit(C_KEYWORD, k, R_KEYWORD, 1'b0);
		endcase
	endfunction

	function automatic void emit_syn_eoc();
		emit(C_EOC, K_NONE, R_SYN_EOC, 1'b1);
	endfunction

	// implicit concatenation between adjacent operands
	function automatic void concat_check(logic [3:0] kind, logic blank);
		if (operand_open && !at_start && kind != RK_EOS && kind != RK_SEMI &&
		    kind != RK_EOL && kind != RK_RPAREN && kind != RK_COMMA) begin
			emit(blank ? C_BLANK_CONCAT : C_CONCAT, K_NONE, R_CONCAT, 1'b1);
			operand_open = 1'b0;
		end
	endfunction

	function automatic void end_clause();
		at_start = 1'b1;
		do_spec = 1'b0;
		parse_phase = PS_NONE;
		addr_tail = 1'b0;
		operand_open = 1'b0;
		end_name_due = 1'b0;
	endfunction

	function automatic void settle();
		at_start = 1'b0;
		operand_open = 1'b0;
	endfunction

	function automatic void restart_clause();
		at_start = 1'b1;
		operand_open = 1'b0;
	endfunction

	function automatic logic select_on_top();
		if (open_groups == 0) return 1'b0;
		return group_is_select[open_groups - 1];
	endfunction

	function automatic void open_group(logic is_sel);
		if (open_groups < GROUP_DEPTH) begin
			group_is_select[open_groups] = is_sel;
			open_groups++;
		end
	endfunction

	function automatic void classify_word(logic [5:0] k, logic blank, logic nc, logic ne);
		logic parse_kw, addr_kw;
		parse_kw = (k == K_ARG) || (k == K_PULL) || (k >= K_UPPER && k <= K_WITH);
		addr_kw = (k == K_VALUE) || (k == K_WITH) || (k >= K_INPUT && k <= K_REPLACE);
		if (at_start && nc) begin
			emit(C_LABEL, K_NONE, R_LABEL, 1'b0);
			emit(C_COLON, K_NONE, R_PUNCT, 1'b0);
			emit_syn_eoc();
			colon_swallow = 1'b1;
			end_clause();
		end else if ((at_start || do_spec) && ne) begin
			concat_check(RK_WORD, blank);
			emit(C_VAR, K_NONE, R_IDENT, 1'b0);
			settle();
		end else if ((if_cond || when_cond) && k == K_THEN) begin
			emit_syn_eoc();
			emit(C_THEN, K_NONE, R_KEYWORD, 1'b0);
			emit_syn_eoc();
			if (if_cond && else_count != 8'd255) else_count++;
			if_cond = 1'b0;
			when_cond = 1'b0;
			restart_clause();
		end else if (k == K_ELSE && else_count != 8'd0) begin
			emit(C_ELSE, K_NONE, R_KEYWORD, 1'b0);
			emit_syn_eoc();
			else_count--;
			restart_clause();
		end else if (end_name_due) begin
			emit(C_VAR, K_NONE, R_END_NAME, 1'b0);
			end_name_due = 1'b0;
			settle();
		end else if (parse_phase == PS_TEMPLATE) begin
			emit(C_VAR, K_NONE, R_PARSE_TARGET, 1'b0);
			settle();
		end else if (parse_phase == PS_VALUE && k == K_WITH) begin
			emit(C_WITH, K_NONE, R_KEYWORD, 1'b0);
			parse_phase = PS_TEMPLATE;
			settle();
		end else if (parse_phase == PS_HEADER && parse_kw) begin
			emit_named(k);
			parse_phase = (k == K_VALUE) ? PS_VALUE : PS_TEMPLATE;
			settle();
		end else if (addr_tail && addr_kw) begin
			emit_named(k);
			settle();
		end else if (do_spec && k >= K_TO && k <= K_FOREVER) begin
			emit_named(k);
			settle();
		end else if (at_start && select_on_top() && k == K_WHEN) begin
			emit(C_WHEN, K_NONE, R_KEYWORD, 1'b0);
			when_cond = 1'b1;
			settle();
		end else if (at_start && select_on_top() && k == K_OTHERWISE) begin
			emit(C_OTHERWISE, K_NONE, R_KEYWORD, 1'b0);
			emit_syn_eoc();
			restart_clause();
		end else if (at_start && k >= K_THEN && k <= K_OTHERWISE) begin
			emit_named(k);
			if (k != K_WHEN) emit_syn_eoc();
			restart_clause();
		end else if (at_start && k == K_END) begin
			emit(C_END, K_NONE, R_KEYWORD, 1'b0);
			if (open_groups != 0) open_groups--;
			end_name_due = 1'b1;
			settle();
		end else if (at_start && k >= K_ADDRESS && k <= K_TRACE) begin
			emit(C_KEYWORD, k, R_KEYWORD, 1'b0);
			if (k == K_IF) if_cond = 1'b1;
			if (k == K_DO) begin
				do_spec = 1'b1;
				open_group(1'b0);
			end
			if (k == K_SELECT) open_group(1'b1);
			if (k == K_PARSE) parse_phase = PS_HEADER;
			if (k == K_ADDRESS) addr_tail = 1'b1;
			settle();
		end else begin
			concat_check(RK_WORD, blank);
			emit(C_VAR, K_NONE, R_IDENT, 1'b0);
			at_start = 1'b0;
			operand_open = 1'b1;
		end
	endfunction

	// expected tokens for one raw token transfer
	function automatic void classify_token(logic [3:0] kind, logic [5:0] code, logic blank,
	                                       logic nc, logic ne);
		logic [5:0] k;
		run_tok_t r;
		step_n = 0;
		k = (code > K_END) ? K_NONE : code;
		if (kind > RK_EOS) return;
		if (colon_swallow) begin
			colon_swallow = 1'b0;
			if (kind == RK_COLON) return;
		end
		case (kind)
			RK_WORD: classify_word(k, blank, nc, ne);
			RK_NUMBER, RK_STRING: begin
				concat_check(kind, blank);
				emit(kind == RK_NUMBER ? C_NUMBER : C_STRING, K_NONE, R_LITERAL, 1'b0);
				at_start = 1'b0;
				operand_open = 1'b1;
			end
			RK_DOT: begin
				emit(C_DOT, K_NONE, parse_phase == PS_TEMPLATE ? R_PARSE_DROP : R_PUNCT, 1'b0);
				settle();
			end
			RK_EQUAL: begin
				emit(C_EQUAL, K_NONE, R_OPERATOR, 1'b0);
				settle();
			end
			RK_PLUS: begin
				emit(C_PLUS, K_NONE, R_OPERATOR, 1'b0);
				settle();
			end
			RK_MINUS: begin
				emit(C_MINUS, K_NONE, R_OPERATOR, 1'b0);
				settle();
			end
			RK_BSLASH: begin
				emit(C_NOT, K_NONE, R_OPERATOR, 1'b0);
				settle();
			end
			RK_LPAREN: begin
				concat_check(kind, blank);
				emit(C_OPEN, K_NONE, R_PUNCT, 1'b0);
				settle();
			end
			RK_RPAREN: begin
				emit(C_CLOSE, K_NONE, R_PUNCT, 1'b0);
				at_start = 1'b0;
				operand_open = 1'b1;
			end
			RK_COMMA: begin
				emit(C_COMMA, K_NONE, R_PUNCT, 1'b0);
				settle();
			end
			RK_SEMI, RK_EOL: begin
				emit(C_EOC, K_NONE, R_EOC, 1'b0);
				end_clause();
			end
			RK_COLON: begin
				emit(C_COLON, K_NONE, R_PUNCT, 1'b0);
				settle();
			end
			default: begin
				emit(C_EOS, K_NONE, R_EOS, 1'b0);
				clear_context();
			end
		endcase
		for (int i = 0; i < step_n; i++) begin
			r.tok = step_toks[i];
			r.last = (i == step_n - 1);
			pending_tokens.push_back(r);
		end
	endfunction

	// compare output transfers, then predict input transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_context();
			pending_tokens.delete();
			failures = 0;
			pending_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_tokens.size() == 0) begin
					$display("%0t: unexpected token class=%0d echo=%0d role=%0d syn=%0d last=%0d",
					         $time, token_class, keyword_echo, token_role, is_synthetic,
					         last_of_run);
					failures++;
				end else begin
					run_tok_t w;
					w = pending_tokens.pop_front();
					if (token_class !== w.tok.token_class) begin
						$display("%0t: token_class expected %0d actual %0d", $time,
						         w.tok.token_class, token_class);
						failures++;
					end
					if (keyword_echo !== w.tok.keyword_echo) begin
						$display("%0t: keyword_echo expected %0d actual %0d", $time,
						         w.tok.keyword_echo, keyword_echo);
						failures++;
					end
					if (token_role !== w.tok.token_role) begin
						$display("%0t: token_role expected %0d actual %0d", $time,
						         w.tok.token_role, token_role);
						failures++;
					end
					if (is_synthetic !== w.tok.is_synthetic) begin
						$display("%0t: is_synthetic expected %0d actual %0d", $time,
						         w.tok.is_synthetic, is_synthetic);
						failures++;
					end
					if (last_of_run !== w.last) begin
						$display("%0t: last_of_run expected %0d actual %0d", $time,
						         w.last, last_of_run);
						failures++;
					end
				end
			end
			if (in_valid && !in_stall)
				classify_token(raw_kind, keyword_code, space_before, next_is_colon, next_is_equal);
			pending_count = pending_tokens.size();
		end
	end

endmodule

// ===== test/contextual_token_classifier_top_tb.sv =====
// testbench top: raw token stimulus, output stall pattern, watchdog and verdict
module contextual_token_classifier_top_tb import ctc_pkg::*;;

	localparam int GROUP_DEPTH = GroupDepthDefault;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 70;
	localparam int QUIET_FROM = 55;
	localparam logic [5:0] K_NOP = 6'd11;
	localparam logic [5:0] K_SAY = 6'd20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [3:0] raw_kind = RK_WORD;
	logic [5:0] keyword_code = K_NONE;
	logic space_before = 1'b0;
	logic next_is_colon = 1'b0;
	logic next_is_equal = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [4:0] token_class;
	logic [5:0] keyword_echo;
	logic [3:0] token_role;
	logic is_synthetic;
	logic last_of_run;

	int failures;
	int pending_count;
	int random_sent = 0;
	logic quiet = 1'b0;
	int stall_left = 0;
	int idle_cycles = 0;

	contextual_token_classifier_top #(.GROUP_DEPTH(GROUP_DEPTH)) u_dut (.*);

	ctc_checker #(.GROUP_DEPTH(GROUP_DEPTH)) u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stall bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 8);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == IDLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// one raw token transfer, with an optional sender gap ahead of it
	task automatic send_token(logic [3:0] kind, logic [5:0] code, logic blank, logic nc,
	                          logic ne);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_kind <= kind;
		keyword_code <= code;
		space_before <= blank;
		next_is_colon <= nc;
		next_is_equal <= ne;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		random_sent++;
	endtask

	task automatic word(logic [5:0] code);
		send_token(RK_WORD, code, 1'(($urandom_range(0, 1))), 1'b0, 1'b0);
	endtask

	task automatic punct(logic [3:0] kind);
		send_token(kind, 6'($urandom_range(0, 63)), 1'(($urandom_range(0, 1))), 1'b0, 1'b0);
	endtask

	// short operand expression, possibly with abutted operands
	task automatic expression();
		int n;
		n = $urandom_range(1, 4);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 6))
				0: word(K_NONE);
				1: punct(RK_NUMBER);
				2: punct(RK_STRING);
				3: begin
					punct(RK_LPAREN);
					word(K_NONE);
					punct(RK_RPAREN);
				end
				4: punct(RK_PLUS);
				5: punct(RK_MINUS);
				default: punct(RK_BSLASH);
			endcase
		end
	endtask

	task automatic end_of_clause();
		punct($urandom_range(0, 3) == 0 ? RK_EOL : RK_SEMI);
	endtask

	// one well-formed or broken clause sequence with random content
	task automatic random_sequence();
		case ($urandom_range(0, 11))
			0: begin
				send_token(RK_WORD, K_NONE, 1'b0, 1'b1, 1'b0);
				punct($urandom_range(0, 3) == 0 ? RK_WORD : RK_COLON);
			end
			1: begin
				word(K_IF);
				expression();
				word(K_THEN);
				word(K_SAY);
				expression();
				end_of_clause();
				if ($urandom_range(0, 1)) begin
					word(K_ELSE);
					word(K_NOP);
					end_of_clause();
				end
			end
			2: begin
				word(K_DO);
				send_token(RK_WORD, K_NONE, 1'b1, 1'b0, 1'b1);
				punct(RK_EQUAL);
				punct(RK_NUMBER);
				word(6'($urandom_range(K_TO, K_FOREVER)));
				punct(RK_NUMBER);
				end_of_clause();
				word(K_SAY);
				expression();
				end_of_clause();
				word(K_END);
				if ($urandom_range(0, 1)) word(K_NONE);
				end_of_clause();
			end
			3: begin
				word(K_SELECT);
				end_of_clause();
				word(K_WHEN);
				expression();
				word(K_THEN);
				word(K_NOP);
				end_of_clause();
				word(K_OTHERWISE);
				word(K_SAY);
				expression();
				end_of_clause();
				word(K_END);
				end_of_clause();
			end
			4: begin
				word(K_PARSE);
				if ($urandom_range(0, 1)) begin
					word(K_VALUE);
					expression();
					word(K_WITH);
				end else begin
					word($urandom_range(0, 1) ? K_ARG : 6'($urandom_range(K_UPPER, K_WITH)));
				end
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 2) == 0) punct(RK_DOT);
					else word(6'($urandom_range(0, 49)));
				end
				end_of_clause();
			end
			5: begin
				word(K_ADDRESS);
				word(6'($urandom_range(K_INPUT, K_REPLACE)));
				word($urandom_range(0, 1) ? K_VALUE : K_WITH);
				expression();
				end_of_clause();
			end
			6: begin
				send_token(RK_WORD, 6'($urandom_range(0, 63)), 1'b0, 1'b0, 1'b1);
				punct(RK_EQUAL);
				expression();
				end_of_clause();
			end
			7: begin
				word(K_SAY);
				expression();
				punct(RK_COMMA);
				expression();
				end_of_clause();
			end
			8, 9: begin
				repeat ($urandom_range(1, 3))
					send_token(4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
					           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					           1'($urandom_range(0, 1)));
			end
			10: begin
				word(6'($urandom_range(K_ADDRESS, K_END)));
				expression();
				end_of_clause();
			end
			default: punct(RK_EOS);
		endcase
	endtask

	// stimulus
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: label with its colon swallowed, field extremes, every raw kind but SEMI and EOS
		send_token(RK_WORD, K_NONE, 1'b0, 1'b1, 1'b0);
		send_token(RK_COLON, 6'd63, 1'b1, 1'b1, 1'b1);
		send_token(RK_WORD, 6'd63, 1'b1, 1'b0, 1'b1);
		send_token(RK_EQUAL, K_END, 1'b0, 1'b0, 1'b0);
		send_token(RK_NUMBER, 6'd63, 1'b0, 1'b0, 1'b0);
		send_token(RK_STRING, K_NONE, 1'b0, 1'b0, 1'b0);
		send_token(RK_WORD, 6'd50, 1'b1, 1'b0, 1'b0);
		send_token(RK_LPAREN, K_NONE, 1'b1, 1'b0, 1'b0);
		send_token(RK_RPAREN, K_NONE, 1'b0, 1'b0, 1'b0);
		send_token(RK_COMMA, K_NONE, 1'b0, 1'b0, 1'b0);
		send_token(RK_PLUS, K_NONE, 1'b0, 1'b0, 1'b0);
		send_token(RK_MINUS, K_NONE, 1'b0, 1'b0, 1'b0);
		send_token(RK_BSLASH, K_NONE, 1'b0, 1'b0, 1'b0);
		send_token(RK_DOT, K_NONE, 1'b0, 1'b0, 1'b0);
		send_token(RK_UNKNOWN, 6'd63, 1'b1, 1'b1, 1'b1);
		send_token(RK_EOL, K_NONE, 1'b0, 1'b0, 1'b0);
		// label followed by something other than a colon
		send_token(RK_WORD, K_NONE, 1'b0, 1'b1, 1'b0);
		send_token(RK_SEMI, K_NONE, 1'b0, 1'b0, 1'b0);
		// END with no open group, then end of source
		word(K_END);
		word(K_NONE);
		punct(RK_SEMI);
		word(K_ELSE);
		word(K_WHEN);
		word(K_OTHERWISE);
		send_token(RK_EOS, K_NONE, 1'b0, 1'b0, 1'b0);

		// group stack filled past its depth, then a few groups closed
		repeat (GROUP_DEPTH + 1) begin
			word($urandom_range(0, 1) ? K_DO : K_SELECT);
			punct(RK_SEMI);
		end
		word(K_WHEN);
		punct(RK_SEMI);
		repeat (3) begin
			word(K_END);
			punct(RK_SEMI);
		end
		punct(RK_EOS);

		// random clause sequences, idling dropped near the end
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			if (random_sent >= QUIET_FROM) quiet = 1'b1;
			random_sequence();
		end
		send_token(RK_EOS, K_NONE, 1'b0, 1'b0, 1'b0);
		in_valid <= 1'b0;

		// drain and settle
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
